// File: hdl/ptd_pkg.sv
`timescale 1ns / 1ps

package ptd_pkg;

	localparam int SMP_W           = 16;
	localparam int IDX_W           = 16;
	localparam int KIND_W          = 2;
	localparam int THR_W           = 15;
	localparam int EXT_W           = 18;
	localparam int MAX_SAMPLES     = 65536;
	localparam int TREND_LOOKAHEAD = 4;
	localparam int CNT_W           = $clog2(MAX_SAMPLES + 1);
	localparam int RPL_W           = (TREND_LOOKAHEAD > 1) ? $clog2(TREND_LOOKAHEAD) : 1;

	localparam int DATA_W    = 32;
	localparam int ADDR_W    = 3;
	localparam int REG_IDX_W = ADDR_W - 2;

	localparam logic [REG_IDX_W-1:0] REG_THR   = '0;
	localparam logic [THR_W-1:0]     THR_RESET = THR_W'(2048);

	localparam logic signed [EXT_W-1:0] SENT_HIGH = EXT_W'(131071);
	localparam logic signed [EXT_W-1:0] SENT_LOW  = EXT_W'(-131072);

	localparam logic [KIND_W-1:0] KIND_TROUGH = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PEAK   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SHORT  = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REPLAY,
		ST_FLUSH
	} ptd_state_t;

	typedef struct packed {
		logic accept;
		logic replay;
		logic flush;
	} ptd_cmd_t;

	typedef struct packed {
		logic trend_start;
		logic pend_valid;
		logic out_free;
		logic replay_last;
	} ptd_sts_t;

	function automatic logic signed [EXT_W-1:0] sext(input logic signed [SMP_W-1:0] v);
		sext = {{(EXT_W - SMP_W){v[SMP_W-1]}}, v};
	endfunction

endpackage

// File: hdl/peak_trough_detector.sv
`timescale 1ns / 1ps

// outside the replay, a result appears in the output register in the cycle after its word is taken
// throughput: one word per cycle once a record is running, while the output register is free
// the fifth word of a record starts a replay: four buffered pairs go through the
// single pair evaluator, then a flush step releases any held result
// reset (arst_n low, asynchronous) clears record state and loads contrast_threshold = 2048

module peak_trough_detector (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [ptd_pkg::ADDR_W-1:0]        paddr,
	input  logic [ptd_pkg::DATA_W-1:0]        pwdata,
	output logic [ptd_pkg::DATA_W-1:0]        prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [ptd_pkg::SMP_W-1:0]  sample,
	input  logic                              last_sample,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [ptd_pkg::IDX_W-1:0]         extremum_index,
	output logic [ptd_pkg::KIND_W-1:0]        extremum_kind,
	output logic signed [ptd_pkg::SMP_W-1:0]  extremum_value,
	output logic                              last_of_run
);
	import ptd_pkg::*;

	logic [THR_W-1:0] thr_q;
	logic             reg_hit;
	ptd_cmd_t         cmd;
	ptd_sts_t         sts;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[ADDR_W-1:2] == REG_THR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			thr_q <= pwdata[THR_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_hit) prdata = DATA_W'(thr_q);
	end

	ptd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	ptd_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.thr            (thr_q),
		.sample         (sample),
		.last_sample    (last_sample),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.extremum_index (extremum_index),
		.extremum_kind  (extremum_kind),
		.extremum_value (extremum_value),
		.last_of_run    (last_of_run)
	);

endmodule

// File: hdl/ptd_ctrl.sv
`timescale 1ns / 1ps

module ptd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  ptd_pkg::ptd_sts_t sts,
	output ptd_pkg::ptd_cmd_t cmd
);
	import ptd_pkg::*;

	ptd_state_t state_q;
	ptd_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.accept && sts.trend_start) state_d = ST_REPLAY;
			end
			ST_REPLAY: begin
				if (cmd.replay && sts.replay_last) state_d = ST_FLUSH;
			end
			ST_FLUSH: begin
				if (cmd.flush) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall   = 1'b1;
		cmd        = '0;
		case (state_q)
			ST_IDLE: begin
				in_stall   = !sts.out_free;
				cmd.accept = in_valid && sts.out_free;
			end
			ST_REPLAY: begin
				// a pending word may need the output register
				cmd.replay = !sts.pend_valid || sts.out_free;
			end
			ST_FLUSH: begin
				cmd.flush = !sts.pend_valid || sts.out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

`ifndef ASSERT_OFF
	a_stall_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall)
		else $error("input taken while replay in progress");

	a_replay_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REPLAY && $past(state_q) == ST_IDLE) |->
		$past(cmd.accept && sts.trend_start))
		else $error("replay entered without a trend start");

	a_flush_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |=> state_q == ST_IDLE)
		else $error("flush did not return to idle");
`endif

endmodule

// File: hdl/ptd_dp.sv
`timescale 1ns / 1ps

module ptd_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ptd_pkg::ptd_cmd_t                 cmd,
	output ptd_pkg::ptd_sts_t                 sts,
	input  logic [ptd_pkg::THR_W-1:0]         thr,
	input  logic signed [ptd_pkg::SMP_W-1:0]  sample,
	input  logic                              last_sample,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [ptd_pkg::IDX_W-1:0]         extremum_index,
	output logic [ptd_pkg::KIND_W-1:0]        extremum_kind,
	output logic signed [ptd_pkg::SMP_W-1:0]  extremum_value,
	output logic                              last_of_run
);
	import ptd_pkg::*;

	localparam logic [CNT_W-1:0] CNT_LOOK = CNT_W'(TREND_LOOKAHEAD);
	localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_SAMPLES);
	localparam logic [RPL_W-1:0] RPL_LAST = RPL_W'(TREND_LOOKAHEAD - 1);

	// record state
	logic                    seek_q;
	logic signed [EXT_W-1:0] min_q;
	logic signed [EXT_W-1:0] max_q;
	logic [IDX_W-1:0]        minpos_q;
	logic [IDX_W-1:0]        maxpos_q;
	logic [CNT_W-1:0]        cnt_q;
	logic signed [SMP_W-1:0] prior_q;
	logic [RPL_W-1:0]        rpl_q;
	logic                    rec_last_q;
	logic                    pend_v_q;
	logic                    out_v_q;

	// startup shift line, sample 0 ends up at tap 0
	logic signed [SMP_W-1:0] tap_q [TREND_LOOKAHEAD+1];

	logic [IDX_W-1:0]        pend_idx_q;
	logic [KIND_W-1:0]       pend_kind_q;
	logic signed [SMP_W-1:0] pend_val_q;

	logic [IDX_W-1:0]        out_idx_q;
	logic [KIND_W-1:0]       out_kind_q;
	logic signed [SMP_W-1:0] out_val_q;
	logic                    out_last_q;

	// pair evaluation
	logic signed [SMP_W-1:0] y1;
	logic signed [SMP_W-1:0] y2;
	logic [IDX_W-1:0]        i1;
	logic signed [EXT_W-1:0] y1x;
	logic signed [EXT_W:0]   y2w;
	logic signed [EXT_W:0]   thr_x;
	logic signed [EXT_W:0]   lim_lo;
	logic signed [EXT_W:0]   lim_hi;
	logic signed [EXT_W-1:0] min_n;
	logic signed [EXT_W-1:0] max_n;
	logic [IDX_W-1:0]        minpos_n;
	logic [IDX_W-1:0]        maxpos_n;
	logic                    fire_t;
	logic                    fire_p;
	logic                    fire;
	logic                    seek_n;
	logic signed [EXT_W-1:0] min_after;
	logic signed [EXT_W-1:0] max_after;
	logic [IDX_W-1:0]        res_idx;
	logic [KIND_W-1:0]       res_kind;
	logic signed [SMP_W-1:0] res_val;
	logic                    out_free;
	logic                    pair_go;

	assign out_free = !out_v_q || !out_stall;
	assign pair_go  = cmd.replay || (cmd.accept && (cnt_q > CNT_LOOK));

	always_comb begin
		y1 = cmd.replay ? tap_q[0] : prior_q;
		y2 = cmd.replay ? tap_q[1] : sample;
		i1 = cmd.replay ? IDX_W'(rpl_q) : IDX_W'(cnt_q - CNT_W'(1));

		y1x   = sext(y1);
		y2w   = {{(EXT_W + 1 - SMP_W){y2[SMP_W-1]}}, y2};
		thr_x = $signed({{(EXT_W + 1 - THR_W){1'b0}}, thr});

		min_n    = min_q;
		minpos_n = minpos_q;
		if (seek_q && (y1x < min_q)) begin
			min_n    = y1x;
			minpos_n = i1;
		end
		max_n    = max_q;
		maxpos_n = maxpos_q;
		if (!seek_q && (y1x > max_q)) begin
			max_n    = y1x;
			maxpos_n = i1;
		end

		lim_lo = {min_n[EXT_W-1], min_n} + thr_x;
		lim_hi = {max_n[EXT_W-1], max_n} - thr_x;

		// the opposite extremum sits at its sentinel and seek_q gates both fires, so one pair fires at most once
		fire_t = seek_q && (y1x > min_n) && (y2w > lim_lo) && (y2 > y1);
		fire_p = !seek_q && (y1x < max_n) && (y2w < lim_hi) && (y2 < y1);
		fire   = fire_t || fire_p;

		seek_n    = fire ? !seek_q : seek_q;
		min_after = fire_t ? SENT_HIGH : min_n;
		max_after = fire_p ? SENT_LOW : max_n;

		res_idx  = fire_t ? minpos_n : maxpos_n;
		res_kind = fire_t ? KIND_TROUGH : KIND_PEAK;
		res_val  = fire_t ? min_n[SMP_W-1:0] : max_n[SMP_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seek_q     <= 1'b0;
			min_q      <= SENT_HIGH;
			max_q      <= SENT_LOW;
			minpos_q   <= '0;
			maxpos_q   <= '0;
			cnt_q      <= '0;
			prior_q    <= '0;
			rpl_q      <= '0;
			rec_last_q <= 1'b0;
			pend_v_q   <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			if (out_v_q && !out_stall) out_v_q <= 1'b0;

			if (pair_go) begin
				seek_q   <= seek_n;
				min_q    <= min_after;
				max_q    <= max_after;
				minpos_q <= minpos_n;
				maxpos_q <= maxpos_n;
			end

			if (cmd.accept) begin
				prior_q    <= sample;
				rec_last_q <= last_sample;
				rpl_q      <= '0;
				if (cnt_q != CNT_MAX) cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_LOOK) seek_q <= (tap_q[1] > sample);
				if ((cnt_q > CNT_LOOK) && fire) out_v_q <= 1'b1;
				if (last_sample && (cnt_q < CNT_LOOK)) out_v_q <= 1'b1;
				// end of record, unless the replay still has to run
				if (last_sample && (cnt_q != CNT_LOOK)) begin
					seek_q   <= 1'b0;
					min_q    <= SENT_HIGH;
					max_q    <= SENT_LOW;
					minpos_q <= '0;
					maxpos_q <= '0;
					cnt_q    <= '0;
					prior_q  <= '0;
				end
			end

			if (cmd.replay) begin
				rpl_q <= rpl_q + RPL_W'(1);
				if (fire) begin
					pend_v_q <= 1'b1;
					if (pend_v_q) out_v_q <= 1'b1;
				end
			end

			if (cmd.flush) begin
				if (pend_v_q) out_v_q <= 1'b1;
				pend_v_q <= 1'b0;
				if (rec_last_q) begin
					seek_q   <= 1'b0;
					min_q    <= SENT_HIGH;
					max_q    <= SENT_LOW;
					minpos_q <= '0;
					maxpos_q <= '0;
					cnt_q    <= '0;
					prior_q  <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			if (cnt_q <= CNT_LOOK) begin
				for (int j = 0; j < TREND_LOOKAHEAD; j++) tap_q[j] <= tap_q[j+1];
				tap_q[TREND_LOOKAHEAD] <= sample;
			end
			if ((cnt_q > CNT_LOOK) && fire) begin
				out_idx_q  <= res_idx;
				out_kind_q <= res_kind;
				out_val_q  <= res_val;
				out_last_q <= 1'b1;
			end
			if (last_sample && (cnt_q < CNT_LOOK)) begin
				out_idx_q  <= '0;
				out_kind_q <= KIND_SHORT;
				out_val_q  <= '0;
				out_last_q <= 1'b1;
			end
		end

		if (cmd.replay) begin
			for (int j = 0; j < TREND_LOOKAHEAD; j++) tap_q[j] <= tap_q[j+1];
			if (fire) begin
				pend_idx_q  <= res_idx;
				pend_kind_q <= res_kind;
				pend_val_q  <= res_val;
				// older pending word is not the last of the run
				if (pend_v_q) begin
					out_idx_q  <= pend_idx_q;
					out_kind_q <= pend_kind_q;
					out_val_q  <= pend_val_q;
					out_last_q <= 1'b0;
				end
			end
		end

		if (cmd.flush && pend_v_q) begin
			out_idx_q  <= pend_idx_q;
			out_kind_q <= pend_kind_q;
			out_val_q  <= pend_val_q;
			out_last_q <= 1'b1;
		end
	end

	assign sts.trend_start = (cnt_q == CNT_LOOK);
	assign sts.pend_valid  = pend_v_q;
	assign sts.out_free    = out_free;
	assign sts.replay_last = (rpl_q == RPL_LAST);

	assign out_valid      = out_v_q;
	assign extremum_index = out_idx_q;
	assign extremum_kind  = out_kind_q;
	assign extremum_value = out_val_q;
	assign last_of_run    = out_last_q;

`ifndef ASSERT_OFF
	a_max_idle_in_trough: assert property (@(posedge clk) disable iff (!arst_n)
		seek_q |-> (max_q == SENT_LOW))
		else $error("running max left its sentinel during trough search");

	a_min_idle_in_peak: assert property (@(posedge clk) disable iff (!arst_n)
		!seek_q |-> (min_q == SENT_HIGH))
		else $error("running min left its sentinel during peak search");

	a_no_pend_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |-> !pend_v_q)
		else $error("new word taken with a result still pending");
`endif

endmodule
